[rtl/cbu_pkg.sv]
// Shared types and constants for the CB-prefix rotate/shift/bit unit.
`timescale 1ns / 1ps
package cbu_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int REG_COUNT = 7;
   localparam int SLOT_W = $clog2(REG_COUNT);

   // operand selector codes
   localparam logic [2:0] SEL_H = 3'd4;
   localparam logic [2:0] SEL_L = 3'd5;
   localparam logic [2:0] SEL_MEM = 3'd6;
   localparam logic [2:0] SEL_A = 3'd7;
   localparam logic [2:0] SEL_FLAGS = 3'd6;

   localparam logic [7:0] TOP_BIT = 8'(1 << 7);

   typedef enum logic [1:0] {
      GRP_SHIFT = 2'd0,
      GRP_BIT = 2'd1,
      GRP_RES = 2'd2,
      GRP_SET = 2'd3
   } cbu_group_type;

   typedef enum logic [2:0] {
      OP_RLC = 3'd0,
      OP_RRC = 3'd1,
      OP_RL = 3'd2,
      OP_RR = 3'd3,
      OP_SLA = 3'd4,
      OP_SRA = 3'd5,
      OP_SWAP = 3'd6,
      OP_SRL = 3'd7
   } cbu_shift_op_type;

   typedef struct packed {
      logic is_load;
      cbu_group_type grp;
      logic [2:0] sub;
      logic [2:0] sel;
      logic [7:0] mem_data;
      logic [7:0] load_value;
   } cbu_item_type;

   typedef struct packed {
      logic [7:0] new_value;
      logic [3:0] flags_out;
      logic [2:0] dest_index;
      logic reg_written;
      logic mem_write;
      logic [15:0] mem_address;
   } cbu_result_type;

   // register file slot of an operand selector; A lives in slot 6
   function automatic logic [SLOT_W-1:0] slot_of(input logic [2:0] sel);
      logic [SLOT_W-1:0] slot;
      slot = (sel == SEL_A) ? SLOT_W'(6) : SLOT_W'(sel);
      return slot;
   endfunction

endpackage

[rtl/cbu_front.sv]
// Front end: accepts and decodes requests into a short queue.
`timescale 1ns / 1ps
module cbu_front
   import cbu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic req_type,
   input  logic [7:0] req_opcode,
   input  logic [7:0] req_mem_data,
   input  logic [2:0] req_load_index,
   input  logic [7:0] req_load_value,
   output logic item_valid,
   output cbu_item_type item,
   input  logic item_take
);

   cbu_item_type item_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   cbu_item_type decoded;
   logic push_ok;
   logic take_ok;

   always_comb begin
      decoded.is_load = req_type;
      decoded.grp = cbu_group_type'(req_opcode[7:6]);
      decoded.sub = req_opcode[5:3];
      decoded.sel = req_type ? req_load_index : req_opcode[2:0];
      decoded.mem_data = req_mem_data;
      decoded.load_value = req_load_value;
   end

   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item = item_ff[rd_ptr_ff];
   assign push_ok = push && !full;
   assign take_ok = item_take && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !take_ok) begin
         count_in = count_ff + 1'b1;
      end else if (take_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         item_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

[rtl/cbu_exec.sv]
// Back end: register file, flags, the operation itself and the result queue.
`timescale 1ns / 1ps
module cbu_exec
   import cbu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic item_valid,
   input  cbu_item_type item,
   output logic item_take,
   input  logic pop,
   output logic empty,
   output cbu_result_type result
);

   logic [7:0] regs_ff [REG_COUNT];
   logic [3:0] flags_ff, flags_in;
   cbu_result_type res_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic out_full;
   logic pop_ok;
   logic [7:0] operand;
   logic [7:0] bit_mask;
   logic [7:0] value;
   logic shifted_out;
   logic is_mem;
   logic reg_we;
   cbu_result_type res;

   assign out_full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign pop_ok = pop && !empty;
   assign item_take = item_valid && (!out_full || pop_ok);
   assign result = res_ff[rd_ptr_ff];

   assign is_mem = (item.sel == SEL_MEM);
   assign operand = is_mem ? item.mem_data : regs_ff[slot_of(item.sel)];
   assign bit_mask = 8'b1 << item.sub;

   always_comb begin
      value = operand;
      shifted_out = 1'b0;
      case (cbu_shift_op_type'(item.sub))
         OP_RLC:  begin value = {operand[6:0], operand[7]}; shifted_out = operand[7]; end
         OP_RRC:  begin value = {operand[0], operand[7:1]}; shifted_out = operand[0]; end
         OP_RL:   begin value = {operand[6:0], flags_ff[0]}; shifted_out = operand[7]; end
         OP_RR:   begin value = {flags_ff[0], operand[7:1]}; shifted_out = operand[0]; end
         OP_SLA:  begin value = {operand[6:0], 1'b0}; shifted_out = operand[7]; end
         OP_SRA:  begin
            value = (operand >> 1) | (operand & TOP_BIT);
            shifted_out = operand[0];
         end
         OP_SWAP: begin value = {operand[3:0], operand[7:4]}; shifted_out = 1'b0; end
         OP_SRL:  begin value = {1'b0, operand[7:1]}; shifted_out = operand[0]; end
         default: begin value = operand; shifted_out = 1'b0; end
      endcase
   end

   always_comb begin
      res.new_value = operand;
      res.dest_index = item.sel;
      res.reg_written = 1'b0;
      res.mem_write = 1'b0;
      res.mem_address = {regs_ff[SLOT_W'(SEL_H)], regs_ff[SLOT_W'(SEL_L)]};
      flags_in = flags_ff;
      reg_we = 1'b0;
      if (item.is_load) begin
         res.new_value = item.load_value;
         if (item.sel == SEL_FLAGS) begin
            flags_in = item.load_value[7:4];
         end else begin
            reg_we = 1'b1;
         end
      end else begin
         case (item.grp)
            GRP_SHIFT: begin
               res.new_value = value;
               flags_in = {(value == 8'h00), 1'b0, 1'b0, shifted_out};
            end
            GRP_BIT: begin
               flags_in = {((operand & bit_mask) == 8'h00), 1'b0, 1'b1, flags_ff[0]};
            end
            GRP_RES: res.new_value = operand & ~bit_mask;
            GRP_SET: res.new_value = operand | bit_mask;
            default: res.new_value = operand;
         endcase
         if (item.grp != GRP_BIT) begin
            res.mem_write = is_mem;
            reg_we = !is_mem;
         end
      end
      res.reg_written = reg_we;
      res.flags_out = flags_in;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (item_take) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (item_take && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !item_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
         flags_ff <= '0;
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
         if (item_take) begin
            flags_ff <= flags_in;
            if (reg_we) begin
               regs_ff[slot_of(item.sel)] <= res.new_value;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         res_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

[rtl/cb_prefix_bit_shift_unit.sv]
// Top level of the CB-prefix rotate/shift/bit unit.
//
// Usage: both channels behave as queues. A transaction enters at a clock
// edge with push high and full low; it either executes one CB-prefixed
// opcode (req_type 0) or loads a register or the flags (req_type 1).
// Exactly one result comes out per transaction, in order; it is on the rsp_
// ports while empty is low and leaves at an edge with pop high.
// Path: a result goes from the decode queue through execute into the result
// queue. Throughput: one transaction per cycle while pop keeps the result
// queue from filling, set by the execute stage that owns the register file
// and flags, so dependent opcodes follow back to back.
// Reset clears the seven registers, the flags and both queues.
// When pop stays low the result queue fills, execution stalls, the decode
// queue fills, and full rises; nothing is dropped.
// For (HL) operands, except BIT, mem_write reports a store of rsp_new_value
// to rsp_mem_address, which always shows H:L as held before the transaction.
`timescale 1ns / 1ps
module cb_prefix_bit_shift_unit
   import cbu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic req_type,
   input  logic [7:0] req_opcode,
   input  logic [7:0] req_mem_data,
   input  logic [2:0] req_load_index,
   input  logic [7:0] req_load_value,
   input  logic pop,
   output logic empty,
   output logic [7:0] rsp_new_value,
   output logic [3:0] rsp_flags_out,
   output logic [2:0] rsp_dest_index,
   output logic rsp_reg_written,
   output logic rsp_mem_write,
   output logic [15:0] rsp_mem_address
);

   logic item_valid;
   logic item_take;
   cbu_item_type item;
   cbu_result_type result;

   cbu_front u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_type(req_type),
      .req_opcode(req_opcode),
      .req_mem_data(req_mem_data),
      .req_load_index(req_load_index),
      .req_load_value(req_load_value),
      .item_valid(item_valid),
      .item(item),
      .item_take(item_take)
   );

   cbu_exec u_exec (
      .clock(clock),
      .reset(reset),
      .item_valid(item_valid),
      .item(item),
      .item_take(item_take),
      .pop(pop),
      .empty(empty),
      .result(result)
   );

   assign rsp_new_value = result.new_value;
   assign rsp_flags_out = result.flags_out;
   assign rsp_dest_index = result.dest_index;
   assign rsp_reg_written = result.reg_written;
   assign rsp_mem_write = result.mem_write;
   assign rsp_mem_address = result.mem_address;

endmodule

[tb/cbu_result_checker.sv]
// Checker for the CB-prefix unit: predicts each result and compares it.
`timescale 1ns / 1ps
module cbu_result_checker
   import cbu_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic full,
   input  logic req_type,
   input  logic [7:0] req_opcode,
   input  logic [7:0] req_mem_data,
   input  logic [2:0] req_load_index,
   input  logic [7:0] req_load_value,
   input  logic pop,
   input  logic empty,
   input  logic [7:0] rsp_new_value,
   input  logic [3:0] rsp_flags_out,
   input  logic [2:0] rsp_dest_index,
   input  logic rsp_reg_written,
   input  logic rsp_mem_write,
   input  logic [15:0] rsp_mem_address,
   output int fail_count,
   output int pending
);

   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;
   localparam int SLOT_OF_A = REG_COUNT - 1;

   logic [7:0] reg_file [REG_COUNT];
   logic [3:0] flag_state;
   cbu_result_type expected_q[$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   task automatic report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   // updates the register file and flags, returns the result of one transaction
   function automatic cbu_result_type apply_transaction(logic is_load, logic [7:0] opc,
                                                        logic [7:0] mem, logic [2:0] lidx,
                                                        logic [7:0] lval);
      cbu_result_type res;
      cbu_group_type grp;
      logic [2:0] sub;
      logic [2:0] sel;
      int slot;
      logic [7:0] v;
      logic carry;
      res = '0;
      res.mem_address = {reg_file[SEL_H], reg_file[SEL_L]};
      if (is_load) begin
         res.dest_index = lidx;
         res.new_value = lval;
         if (lidx == SEL_FLAGS) begin
            flag_state = lval[7:4];
         end else begin
            slot = (lidx == SEL_A) ? SLOT_OF_A : int'(lidx);
            reg_file[slot] = lval;
            res.reg_written = 1'b1;
         end
      end else begin
         grp = cbu_group_type'(opc[7:6]);
         sub = opc[5:3];
         sel = opc[2:0];
         slot = (sel == SEL_A) ? SLOT_OF_A : int'(sel);
         v = (sel == SEL_MEM) ? mem : reg_file[slot];
         res.dest_index = sel;
         case (grp)
            GRP_SHIFT: begin
               case (cbu_shift_op_type'(sub))
                  OP_RLC: begin carry = v[7]; res.new_value = {v[6:0], v[7]}; end
                  OP_RRC: begin carry = v[0]; res.new_value = {v[0], v[7:1]}; end
                  OP_RL: begin carry = v[7]; res.new_value = {v[6:0], flag_state[FLAG_C]}; end
                  OP_RR: begin carry = v[0]; res.new_value = {flag_state[FLAG_C], v[7:1]}; end
                  OP_SLA: begin carry = v[7]; res.new_value = {v[6:0], 1'b0}; end
                  OP_SRA: begin carry = v[0]; res.new_value = {v[7], v[7:1]}; end
                  OP_SWAP: begin carry = 1'b0; res.new_value = {v[3:0], v[7:4]}; end
                  default: begin carry = v[0]; res.new_value = {1'b0, v[7:1]}; end
               endcase
               flag_state = '0;
               flag_state[FLAG_Z] = (res.new_value == 8'd0);
               flag_state[FLAG_C] = carry;
            end
            GRP_BIT: begin
               res.new_value = v;
               flag_state[FLAG_Z] = ~v[sub];
               flag_state[FLAG_N] = 1'b0;
               flag_state[FLAG_H] = 1'b1;
            end
            GRP_RES: res.new_value = v & ~(8'd1 << sub);
            default: res.new_value = v | (8'd1 << sub);
         endcase
         if (grp != GRP_BIT) begin
            if (sel == SEL_MEM) begin
               res.mem_write = 1'b1;
            end else begin
               reg_file[slot] = res.new_value;
               res.reg_written = 1'b1;
            end
         end
      end
      res.flags_out = flag_state;
      return res;
   endfunction

   always @(posedge clock) begin
      cbu_result_type want;
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) reg_file[i] = '0;
         flag_state = '0;
         expected_q.delete();
      end else begin
         if (pop && !empty) begin
            if (expected_q.size() == 0) begin
               report_mismatch("result with no transaction outstanding");
            end else begin
               want = expected_q.pop_front();
               check_field("new_value", 16'(rsp_new_value), 16'(want.new_value));
               check_field("flags_out", 16'(rsp_flags_out), 16'(want.flags_out));
               check_field("dest_index", 16'(rsp_dest_index), 16'(want.dest_index));
               check_field("reg_written", 16'(rsp_reg_written), 16'(want.reg_written));
               check_field("mem_write", 16'(rsp_mem_write), 16'(want.mem_write));
               check_field("mem_address", rsp_mem_address, want.mem_address);
            end
         end
         // results trail their transaction through both queues, so compare before queuing
         if (push && !full)
            expected_q.push_back(apply_transaction(req_type, req_opcode, req_mem_data,
                                                   req_load_index, req_load_value));
      end
      pending <= expected_q.size();
   end

endmodule

[tb/cb_prefix_bit_shift_unit_tb.sv]
// Testbench top for the CB-prefix unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module cb_prefix_bit_shift_unit_tb;
   import cbu_pkg::*;

   localparam logic REQ_EXEC = 1'b0;
   localparam logic REQ_LOAD = 1'b1;
   localparam logic [2:0] SEL_B = 3'd0;
   localparam logic [2:0] SEL_C = 3'd1;
   localparam logic [2:0] SEL_D = 3'd2;
   localparam logic [2:0] SEL_E = 3'd3;
   localparam int RANDOM_ITEMS = 550;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic req_type = 1'b0;
   logic [7:0] req_opcode = '0;
   logic [7:0] req_mem_data = '0;
   logic [2:0] req_load_index = '0;
   logic [7:0] req_load_value = '0;
   logic pop = 1'b0;
   logic full;
   logic empty;
   logic [7:0] rsp_new_value;
   logic [3:0] rsp_flags_out;
   logic [2:0] rsp_dest_index;
   logic rsp_reg_written;
   logic rsp_mem_write;
   logic [15:0] rsp_mem_address;
   int fail_count;
   int pending;
   int cycle_count = 0;
   int stall_left = 0;
   bit steady = 1'b0;

   cb_prefix_bit_shift_unit dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_type(req_type),
      .req_opcode(req_opcode),
      .req_mem_data(req_mem_data),
      .req_load_index(req_load_index),
      .req_load_value(req_load_value),
      .pop(pop),
      .empty(empty),
      .rsp_new_value(rsp_new_value),
      .rsp_flags_out(rsp_flags_out),
      .rsp_dest_index(rsp_dest_index),
      .rsp_reg_written(rsp_reg_written),
      .rsp_mem_write(rsp_mem_write),
      .rsp_mem_address(rsp_mem_address)
   );

   cbu_result_checker checker_i (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_type(req_type),
      .req_opcode(req_opcode),
      .req_mem_data(req_mem_data),
      .req_load_index(req_load_index),
      .req_load_value(req_load_value),
      .pop(pop),
      .empty(empty),
      .rsp_new_value(rsp_new_value),
      .rsp_flags_out(rsp_flags_out),
      .rsp_dest_index(rsp_dest_index),
      .rsp_reg_written(rsp_reg_written),
      .rsp_mem_write(rsp_mem_write),
      .rsp_mem_address(rsp_mem_address),
      .fail_count(fail_count),
      .pending(pending)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // extremes show up often enough to hit carry and zero cases
   function automatic logic [7:0] pick_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 12) return 8'h00;
      if (roll < 24) return 8'hFF;
      if (roll < 30) return 8'h80;
      if (roll < 36) return 8'h01;
      return 8'($urandom);
   endfunction

   function automatic logic [7:0] make_opcode(cbu_group_type grp, logic [2:0] sub,
                                              logic [2:0] sel);
      return {grp, sub, sel};
   endfunction

   // push stays high into the next transaction unless a gap follows
   task automatic send_transaction(logic kind, logic [7:0] opc, logic [7:0] mem,
                                   logic [2:0] lidx, logic [7:0] lval);
      push <= 1'b1;
      req_type <= kind;
      req_opcode <= opc;
      req_mem_data <= mem;
      req_load_index <= lidx;
      req_load_value <= lval;
      do @(posedge clock); while (full);
      if (!steady) begin
         int gap;
         gap = pick_gap();
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // result side: random stalls, with stall-free stretches
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (stall_left > 0) begin
         pop <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         pop <= 1'b1;
         if (((cycle_count >> 8) & 3) != 0 && $urandom_range(0, 3) == 0)
            stall_left <= pick_gap();
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: loads at the extremes, every shift op, BIT/RES/SET, memory operands
      send_transaction(REQ_LOAD, 8'h00, 8'h00, SEL_B, 8'h80);
      send_transaction(REQ_LOAD, 8'h00, 8'h00, SEL_C, 8'h01);
      send_transaction(REQ_LOAD, 8'h00, 8'h00, SEL_D, 8'hFF);
      send_transaction(REQ_LOAD, 8'h00, 8'h00, SEL_E, 8'h00);
      send_transaction(REQ_LOAD, 8'h00, 8'h00, SEL_H, 8'hAB);
      send_transaction(REQ_LOAD, 8'h00, 8'h00, SEL_L, 8'hCD);
      send_transaction(REQ_LOAD, 8'h00, 8'h00, SEL_A, 8'h81);
      send_transaction(REQ_LOAD, 8'h00, 8'h00, SEL_FLAGS, 8'hFF);
      send_transaction(REQ_EXEC, make_opcode(GRP_SHIFT, OP_RLC, SEL_A), 8'h00, 3'd0, 8'h00);
      send_transaction(REQ_EXEC, make_opcode(GRP_SHIFT, OP_RRC, SEL_C), 8'h00, 3'd0, 8'h00);
      send_transaction(REQ_EXEC, make_opcode(GRP_SHIFT, OP_RL, SEL_B), 8'h00, 3'd0, 8'h00);
      send_transaction(REQ_EXEC, make_opcode(GRP_SHIFT, OP_RR, SEL_D), 8'h00, 3'd0, 8'h00);
      send_transaction(REQ_EXEC, make_opcode(GRP_SHIFT, OP_SLA, SEL_A), 8'h00, 3'd0, 8'h00);
      send_transaction(REQ_EXEC, make_opcode(GRP_SHIFT, OP_SRA, SEL_MEM), 8'h80, 3'd0, 8'h00);
      send_transaction(REQ_EXEC, make_opcode(GRP_SHIFT, OP_SWAP, SEL_E), 8'h00, 3'd0, 8'h00);
      send_transaction(REQ_EXEC, make_opcode(GRP_SHIFT, OP_SRL, SEL_MEM), 8'h01, 3'd0, 8'h00);
      send_transaction(REQ_EXEC, make_opcode(GRP_BIT, 3'd7, SEL_MEM), 8'h7F, 3'd0, 8'h00);
      send_transaction(REQ_EXEC, make_opcode(GRP_BIT, 3'd0, SEL_A), 8'h00, 3'd0, 8'h00);
      send_transaction(REQ_EXEC, make_opcode(GRP_RES, 3'd7, SEL_H), 8'h00, 3'd0, 8'h00);
      send_transaction(REQ_EXEC, make_opcode(GRP_SET, 3'd0, SEL_MEM), 8'h00, 3'd0, 8'h00);
      send_transaction(REQ_EXEC, make_opcode(GRP_SET, 3'd7, SEL_L), 8'h00, 3'd0, 8'h00);
      // low nibble of a flags load must be dropped
      send_transaction(REQ_LOAD, 8'h00, 8'h00, SEL_FLAGS, 8'h0F);
      send_transaction(REQ_EXEC, make_opcode(GRP_SHIFT, OP_RL, SEL_A), 8'h00, 3'd0, 8'h00);
      send_transaction(REQ_EXEC, 8'hFF, 8'hFF, 3'd7, 8'hFF);
      send_transaction(REQ_EXEC, 8'h00, 8'h00, 3'd0, 8'h00);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 4) == 0)
            send_transaction(REQ_LOAD, 8'($urandom), pick_byte(),
                             3'($urandom_range(0, 7)), pick_byte());
         else
            send_transaction(REQ_EXEC, 8'($urandom), pick_byte(),
                             3'($urandom_range(0, 7)), pick_byte());
      end
      push <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
